@@ hdl/ppsea_pkg.sv @@
`default_nettype none
package ppsea_pkg;

  localparam int FRAC_BITS_DEF        = 24;
  localparam int COS_TABLE_DEPTH_DEF  = 1024;
  localparam int LEVEL_INDEX_BITS_DEF = 12;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // pi in Q2.30 and one in Q30
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam int          Q30_SH  = 30;

  // Term as the front hands it to the back: signs folded, magnitudes only.
  typedef struct packed {
    logic        neg;
    logic        zero_d;
    logic [33:0] ad;
    logic [31:0] aw;
    logic [31:0] af;
    logic [31:0] ap;
    logic        last;
  } ppsea_term_t;

  // Horner divisors of the sine series, innermost first.
  function automatic logic [7:0] horner_div(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'd210;
      3'd1:    r = 8'd156;
      3'd2:    r = 8'd110;
      3'd3:    r = 8'd72;
      3'd4:    r = 8'd42;
      3'd5:    r = 8'd20;
      3'd6:    r = 8'd6;
      default: r = 8'd1;
    endcase
    return r;
  endfunction

  // Reciprocals of the Horner divisors. For a dividend below 2^32,
  // floor(n / div) = (n * M) >> S with S = 32 + ceil(log2(div)) and
  // M = ceil(2^S / div); the rounding error of M never reaches the next integer.
  function automatic logic [32:0] horner_recip(input logic [2:0] idx);
    logic [32:0] r;
    case (idx)
      3'd0:    r = 33'(((64'd1 << 40) + 64'd209) / 64'd210);
      3'd1:    r = 33'(((64'd1 << 40) + 64'd155) / 64'd156);
      3'd2:    r = 33'(((64'd1 << 39) + 64'd109) / 64'd110);
      3'd3:    r = 33'(((64'd1 << 39) + 64'd71) / 64'd72);
      3'd4:    r = 33'(((64'd1 << 38) + 64'd41) / 64'd42);
      3'd5:    r = 33'(((64'd1 << 37) + 64'd19) / 64'd20);
      3'd6:    r = 33'(((64'd1 << 35) + 64'd5) / 64'd6);
      default: r = 33'h1_0000_0000;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] horner_shift(input logic [2:0] idx);
    logic [5:0] r;
    case (idx)
      3'd0:    r = 6'd40;
      3'd1:    r = 6'd40;
      3'd2:    r = 6'd39;
      3'd3:    r = 6'd39;
      3'd4:    r = 6'd38;
      3'd5:    r = 6'd37;
      3'd6:    r = 6'd35;
      default: r = 6'd32;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/ppsea_front.sv @@
`default_nettype none
module ppsea_front #(
  parameter int LEVEL_INDEX_BITS = ppsea_pkg::LEVEL_INDEX_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic [11:0]            cfg_wr_data,
  input  wire logic [31:0]            target_energy,
  input  wire logic [31:0]            level_energy,
  input  wire logic [11:0]            level_index,
  input  wire logic [31:0]            pole_freq,
  input  wire logic [31:0]            pole_weight,
  input  wire logic [31:0]            overlap_product,
  input  wire logic                   last,
  output ppsea_pkg::ppsea_term_t      term
);

  localparam logic [11:0] LEVEL_MASK =
    (LEVEL_INDEX_BITS >= 12) ? 12'hFFF : 12'((1 << LEVEL_INDEX_BITS) - 1);

  logic [11:0]        highest_occupied;
  logic               occupied;
  logic signed [33:0] diff;
  logic signed [33:0] d;

  always_ff @(posedge clk) begin
    if (rst) begin
      highest_occupied <= '0;
    end else if (cfg_wr_en) begin
      highest_occupied <= cfg_wr_data;
    end
  end

  always_comb begin
    occupied = (level_index & LEVEL_MASK) <= (highest_occupied & LEVEL_MASK);
    diff = 34'(signed'(target_energy)) - 34'(signed'(level_energy));
    d = occupied ? diff + 34'(signed'(pole_freq)) : diff - 34'(signed'(pole_freq));
    term.neg    = pole_weight[31] ^ pole_freq[31] ^ d[33] ^ overlap_product[31];
    term.zero_d = (d == '0);
    term.ad     = d[33] ? 34'(-d) : 34'(d);
    term.aw     = pole_weight[31] ? 32'(-pole_weight) : pole_weight;
    term.af     = pole_freq[31] ? 32'(-pole_freq) : pole_freq;
    term.ap     = overlap_product[31] ? 32'(-overlap_product) : overlap_product;
    term.last   = last;
  end

endmodule
`default_nettype wire

@@ hdl/ppsea_fifo.sv @@
`default_nettype none
module ppsea_fifo (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire ppsea_pkg::ppsea_term_t wr_data,
  output logic                        full,
  input  wire logic                   pop,
  output ppsea_pkg::ppsea_term_t      rd_data,
  output logic                        not_empty
);

  localparam int D  = ppsea_pkg::QUEUE_DEPTH;
  localparam int AW = ppsea_pkg::QUEUE_AW;

  ppsea_pkg::ppsea_term_t slots [D];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full      = (count == (AW+1)'(D));
  assign not_empty = (count != '0);
  assign rd_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(D - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= (rd_ptr == AW'(D - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && not_empty);
    end
  end

endmodule
`default_nettype wire

@@ hdl/ppsea_mul.sv @@
`default_nettype none
module ppsea_mul (
  input  wire logic        clk,
  input  wire logic [32:0] a,
  input  wire logic [32:0] b,
  output logic [65:0]      prod
);

  always_ff @(posedge clk) begin
    prod <= 66'(a) * 66'(b);
  end

endmodule
`default_nettype wire

@@ hdl/ppsea_div.sv @@
`default_nettype none
module ppsea_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [33:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);

  // Restoring division, one quotient bit per cycle.
  logic        busy;
  logic [5:0]  cnt;
  logic [33:0] rem;
  logic [33:0] dsr;
  logic [34:0] rem_sh;
  logic [33:0] rem_next;
  logic        qbit;

  always_comb begin
    rem_sh = {rem, quotient[63]};
    if (rem_sh >= {1'b0, dsr}) begin
      rem_next = 34'(rem_sh - {1'b0, dsr});
      qbit     = 1'b1;
    end else begin
      rem_next = rem_sh[33:0];
      qbit     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[62:0], qbit};
    end
  end

endmodule
`default_nettype wire

@@ hdl/ppsea_back.sv @@
`default_nettype none
module ppsea_back #(
  parameter int FRAC_BITS       = ppsea_pkg::FRAC_BITS_DEF,
  parameter int COS_TABLE_DEPTH = ppsea_pkg::COS_TABLE_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ppsea_pkg::ppsea_term_t q_data,
  input  wire logic                   q_valid,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [31:0]                 sigma_value,
  output logic                        overflow
);

  localparam int F  = FRAC_BITS;
  localparam int KW = $clog2(COS_TABLE_DEPTH);
  localparam logic [63:0] FMASK = (64'd1 << F) - 64'd1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_AB, ST_AB_W, ST_X, ST_X_W, ST_X2, ST_X2_W, ST_T, ST_T_W, ST_T_DIV,
    ST_S, ST_S_W, ST_W, ST_W_W, ST_AH, ST_AH_W, ST_AL, ST_AL_W, ST_DIV, ST_DIV_W,
    ST_QH, ST_QH_W, ST_QL, ST_QL_W, ST_ACC, ST_EMIT
  } state_t;

  state_t                  state;
  ppsea_pkg::ppsea_term_t  cur;
  logic [63:0]             a;
  logic [63:0]             part;
  logic [63:0]             q;
  logic [30:0]             x;
  logic [31:0]             x2;
  logic [30:0]             t;
  logic [31:0]             s;
  logic [31:0]             wnd;
  logic [2:0]              hstep;
  logic [31:0]             mag;
  logic                    sat;
  logic signed [63:0]      running_sum;
  logic                    sticky_overflow;

  logic [32:0]  mul_a;
  logic [32:0]  mul_b;
  logic [65:0]  prod;
  logic         div_start;
  logic [63:0]  div_num;
  logic [33:0]  div_den;
  logic         div_done;
  logic [63:0]  quo;
  logic [63:0]  kwide;
  logic [KW-1:0] k;
  logic [31:0]  limit;
  logic [63:0]  mfull;
  logic signed [63:0] term;
  logic signed [64:0] sum_ext;

  ppsea_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  ppsea_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor(div_den), .done(div_done), .quotient(quo)
  );

  always_comb begin
    kwide = ({30'b0, cur.ad} << (KW + 1)) >> F;
    k     = kwide[KW-1:0];
    limit = cur.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mfull = part + 64'(prod >> F);
    term  = cur.neg ? -signed'(64'(mag)) : signed'(64'(mag));
    sum_ext = 65'(running_sum) + 65'(term);
    q_pop = (state == ST_IDLE) && q_valid;
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_AB:   begin mul_a = {1'b0, cur.aw};    mul_b = {1'b0, cur.af}; end
      ST_X:    begin mul_a = {1'b0, ppsea_pkg::PI_Q30}; mul_b = 33'(k); end
      ST_X2:   begin mul_a = 33'(x);            mul_b = 33'(x);         end
      ST_T:    begin mul_a = 33'(x2);           mul_b = 33'(t);         end
      // Horner division by a constant through its reciprocal.
      ST_T_W:  begin
        mul_a = 33'(prod >> ppsea_pkg::Q30_SH);
        mul_b = ppsea_pkg::horner_recip(hstep);
      end
      ST_S:    begin mul_a = 33'(x);            mul_b = 33'(t);         end
      ST_W:    begin mul_a = 33'(s);            mul_b = 33'(s);         end
      ST_AH:   begin mul_a = 33'(a >> F);       mul_b = 33'(wnd);       end
      ST_AL:   begin mul_a = 33'(a & FMASK);    mul_b = 33'(wnd);       end
      ST_QH:   begin mul_a = 33'(q >> F);       mul_b = {1'b0, cur.ap}; end
      ST_QL:   begin mul_a = 33'(q & FMASK);    mul_b = {1'b0, cur.ap}; end
      default: begin mul_a = '0;                mul_b = '0;             end
    endcase
    div_start = (state == ST_DIV);
    div_num   = a << F;
    div_den   = cur.ad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      running_sum     <= '0;
      sticky_overflow <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (state == ST_EMIT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur <= q_data;
            if (q_data.zero_d) begin
              mag   <= '0;
              sat   <= 1'b0;
              state <= ST_ACC;
            end else begin
              state <= ST_AB;
            end
          end
        end
        ST_AB: state <= ST_AB_W;
        ST_AB_W: begin
          a     <= 64'(prod >> F);
          state <= ((cur.ad >> (F - 1)) == '0) ? ST_X : ST_DIV;
        end
        ST_X: state <= ST_X_W;
        ST_X_W: begin
          x     <= 31'(prod >> (KW + 1));
          state <= ST_X2;
        end
        ST_X2: state <= ST_X2_W;
        ST_X2_W: begin
          x2    <= 32'(prod >> ppsea_pkg::Q30_SH);
          t     <= ppsea_pkg::Q30_ONE;
          hstep <= '0;
          state <= ST_T;
        end
        ST_T:   state <= ST_T_W;
        ST_T_W: state <= ST_T_DIV;
        ST_T_DIV: begin
          t     <= ppsea_pkg::Q30_ONE - 31'(prod >> ppsea_pkg::horner_shift(hstep));
          hstep <= hstep + 1'b1;
          state <= (hstep == 3'd6) ? ST_S : ST_T;
        end
        ST_S: state <= ST_S_W;
        ST_S_W: begin
          s     <= 32'(prod >> ppsea_pkg::Q30_SH);
          state <= ST_W;
        end
        ST_W: state <= ST_W_W;
        ST_W_W: begin
          // sin^2 in Q60, brought down to the fraction width
          wnd   <= 32'(prod >> (2 * ppsea_pkg::Q30_SH - F));
          state <= ST_AH;
        end
        ST_AH: state <= ST_AH_W;
        ST_AH_W: begin
          part  <= 64'(prod);
          state <= ST_AL;
        end
        ST_AL: state <= ST_AL_W;
        ST_AL_W: begin
          a     <= mfull;
          state <= ST_DIV;
        end
        ST_DIV: state <= ST_DIV_W;
        ST_DIV_W: begin
          if (div_done) begin
            q <= quo;
            if (cur.ap == '0 || quo == '0) begin
              mag   <= '0;
              sat   <= 1'b0;
              state <= ST_ACC;
            end else if ((quo >> (31 + F)) != '0) begin
              mag   <= limit;
              sat   <= 1'b1;
              state <= ST_ACC;
            end else begin
              state <= ST_QH;
            end
          end
        end
        ST_QH: state <= ST_QH_W;
        ST_QH_W: begin
          part  <= 64'(prod);
          state <= ST_QL;
        end
        ST_QL: state <= ST_QL_W;
        ST_QL_W: begin
          if (mfull > 64'(limit)) begin
            mag <= limit;
            sat <= 1'b1;
          end else begin
            mag <= mfull[31:0];
            sat <= 1'b0;
          end
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (sum_ext[64] != sum_ext[63]) begin
            running_sum     <= sum_ext[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
            sticky_overflow <= 1'b1;
          end else begin
            running_sum     <= sum_ext[63:0];
            sticky_overflow <= sticky_overflow | sat;
          end
          state <= cur.last ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            if (running_sum > 64'sh7FFF_FFFF) begin
              sigma_value <= 32'h7FFF_FFFF;
              overflow    <= 1'b1;
            end else if (running_sum < -64'sh8000_0000) begin
              sigma_value <= 32'h8000_0000;
              overflow    <= 1'b1;
            end else begin
              sigma_value <= running_sum[31:0];
              overflow    <= sticky_overflow;
            end
            running_sum     <= '0;
            sticky_overflow <= 1'b0;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/plasmon_pole_self_energy_accumulator.sv @@
// Channel   Direction  Payload
// s_axis    in         tdata: target, level energy, level index, freq, weight, overlap
//                      tlast: last term of the element
// m_axis    out        tdata: sigma_value; tuser: overflow
// cfg       in         highest_occupied (12 bits), write only
//
// An accepted beat is registered in the term queue; the back takes it when idle. A
// zero denominator goes straight to accumulation; any other term passes the shared
// multiplier and the divider, with the sine window first when |d| is below one half;
// the last term of an element also passes the emit state. The serial divider for the
// 64-bit main quotient dominates; the sine series runs on the multiplier by reciprocals.
// Reset is synchronous; it clears the sum, the overflow flag and the config register.
// Input stalls only when the two-entry term queue is full; a held result lets the next
// element's terms run but holds the back at its emission, so later terms wait.
`default_nettype none
module plasmon_pole_self_energy_accumulator #(
  parameter int FRAC_BITS        = ppsea_pkg::FRAC_BITS_DEF,
  parameter int COS_TABLE_DEPTH  = ppsea_pkg::COS_TABLE_DEPTH_DEF,
  parameter int LEVEL_INDEX_BITS = ppsea_pkg::LEVEL_INDEX_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic [11:0]  cfg_wr_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // target_energy[31:0], level_energy[63:32], level_index[75:64],
  // pole_freq[107:76], pole_weight[139:108], overlap_product[171:140], zero pad
  input  wire logic [175:0] s_axis_tdata,
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // sigma_value[31:0]
  output logic [31:0]       m_axis_tdata,
  // overflow[0]
  output logic              m_axis_tuser
);

  ppsea_pkg::ppsea_term_t front_term;
  ppsea_pkg::ppsea_term_t queue_term;
  logic queue_full;
  logic queue_valid;
  logic queue_pop;

  // The front classifies each beat (occupied or not) and folds the signs.
  ppsea_front #(.LEVEL_INDEX_BITS(LEVEL_INDEX_BITS)) u_front (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .target_energy(s_axis_tdata[31:0]), .level_energy(s_axis_tdata[63:32]),
    .level_index(s_axis_tdata[75:64]), .pole_freq(s_axis_tdata[107:76]),
    .pole_weight(s_axis_tdata[139:108]), .overlap_product(s_axis_tdata[171:140]),
    .last(s_axis_tlast), .term(front_term)
  );

  assign s_axis_tready = !queue_full;

  ppsea_fifo u_queue (
    .clk(clk), .rst(rst), .push(s_axis_tvalid), .wr_data(front_term),
    .full(queue_full), .pop(queue_pop), .rd_data(queue_term), .not_empty(queue_valid)
  );

  // The back runs the term arithmetic on a shared multiplier and divider,
  // accumulates, and holds the result in its output register.
  ppsea_back #(.FRAC_BITS(FRAC_BITS), .COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .q_data(queue_term), .q_valid(queue_valid), .q_pop(queue_pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .sigma_value(m_axis_tdata), .overflow(m_axis_tuser)
  );

endmodule
`default_nettype wire
